### src/stereo_nearest_point_matcher_unit_assert.svh
// assertion macros shared by the matcher checker
// expects signals clk and arst_n in the scope where a macro is used
`ifndef STEREO_NEAREST_POINT_MATCHER_UNIT_ASSERT_SVH
`define STEREO_NEAREST_POINT_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define SNPM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, ignored while in reset
`define SNPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/snpm_pkg.sv
// shared constants, opcodes and controller/datapath interface types
// used by every module of the nearest point matcher
`timescale 1ns / 1ps

package snpm_pkg;

	localparam int MAX_POINTS  = 16;
	localparam int COORD_W     = 12;
	localparam int OP_W        = 2;
	localparam int MATCH_IDX_W = 4;
	localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int SQ_W        = 2 * COORD_W;
	localparam int DIST_W      = SQ_W + 1;
	localparam int PIPE_DEPTH  = 3;

	localparam logic [COORD_W-1:0] TOL_RESET = COORD_W'(10);

	// input opcodes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic start;
		logic issue;
		logic publish;
	} snpm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic scan_last;
	} snpm_sts_t;

endpackage

### src/stereo_nearest_point_matcher_unit.sv
// top level of the stereo nearest point matcher
// depends on snpm_pkg, snpm_ctrl and snpm_dp
//
//   channel   direction   handshake             payload
//   in        input       in_valid / in_stall   opcode, point_x, point_y
//   out       output      out_valid / out_stall match_found, match_index
//   cfg       input       cfg_we                cfg_wdata (y tolerance)
//
// clear and load transactions are taken back to back
// a query stalls the input until its result is published:
// one distance pipeline walks the point store one entry a cycle, then drains
// reset is asynchronous, active low; the tolerance returns to 10 and the store count to 0
// a query result waits in the output register while out_stall is high; a following
// clear or load is still taken, the next result waits until that register frees
`timescale 1ns / 1ps

module stereo_nearest_point_matcher_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [snpm_pkg::OP_W-1:0]          opcode,
	input  logic [snpm_pkg::COORD_W-1:0]       point_x,
	input  logic [snpm_pkg::COORD_W-1:0]       point_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               match_found,
	output logic [snpm_pkg::MATCH_IDX_W-1:0]   match_index,
	input  logic                               cfg_we,
	input  logic [snpm_pkg::COORD_W-1:0]       cfg_wdata
);
	import snpm_pkg::*;

	snpm_cmd_t cmd;
	snpm_sts_t sts;

	// sequencing
	snpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store and distance search
	snpm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_x     (point_x),
		.point_y     (point_y),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.sts         (sts),
		.match_found (match_found),
		.match_index (match_index)
	);

endmodule

### src/snpm_ctrl.sv
// sequencing state machine of the matcher: handshakes, scan and drain control
// depends on snpm_pkg
`timescale 1ns / 1ps

module snpm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [snpm_pkg::OP_W-1:0]   opcode,
	output logic                        out_valid,
	input  logic                        out_stall,
	input  snpm_pkg::snpm_sts_t         sts,
	output snpm_pkg::snpm_cmd_t         cmd
);
	import snpm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam int DRAIN_W = (PIPE_DEPTH > 1) ? $clog2(PIPE_DEPTH) : 1;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(PIPE_DEPTH - 1);

	state_t               state_q;
	logic [DRAIN_W-1:0]   drain_q;
	logic                 out_valid_q;
	logic                 accept;

	// input transactions are taken only between queries
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.issue   = (state_q == ST_SCAN);
		cmd.publish = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
		if (accept) begin
			case (opcode)
				OP_CLEAR: cmd.clear = 1'b1;
				OP_LOAD:  cmd.load  = 1'b1;
				OP_QUERY: cmd.start = 1'b1;
				default:  ;
			endcase
		end
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					drain_q <= '0;
					if (cmd.start) begin
						state_q <= sts.empty ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					drain_q <= '0;
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= ST_FINISH;
					end else begin
						drain_q <= drain_q + DRAIN_W'(1);
					end
				end
				ST_FINISH: begin
					if (cmd.publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// result register occupancy
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/snpm_dp.sv
// datapath: point store, distance pipeline, best tracker and result register
// depends on snpm_pkg
`timescale 1ns / 1ps

module snpm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [snpm_pkg::COORD_W-1:0]       point_x,
	input  logic [snpm_pkg::COORD_W-1:0]       point_y,
	input  logic                               cfg_we,
	input  logic [snpm_pkg::COORD_W-1:0]       cfg_wdata,
	input  snpm_pkg::snpm_cmd_t                cmd,
	output snpm_pkg::snpm_sts_t                sts,
	output logic                               match_found,
	output logic [snpm_pkg::MATCH_IDX_W-1:0]   match_index
);
	import snpm_pkg::*;

	// point store
	logic [COORD_W-1:0] mem_x [MAX_POINTS];
	logic [COORD_W-1:0] mem_y [MAX_POINTS];

	logic [COORD_W-1:0]  tol_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    scan_idx_q;
	logic [COORD_W-1:0]  qx_q;
	logic [COORD_W-1:0]  qy_q;

	logic [COORD_W-1:0]  rd_x_s1, rd_y_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                vld_s1;

	logic [COORD_W-1:0]  dx_s2, dy_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic                ok_s2, vld_s2;

	logic [SQ_W-1:0]     sqx_s3, sqy_s3;
	logic [IDX_W-1:0]    idx_s3;
	logic                ok_s3, vld_s3;

	logic [DIST_W-1:0]   best_dist_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic                found_q;

	logic                match_found_q;
	logic [MATCH_IDX_W-1:0] match_index_q;

	logic                          not_full;
	logic [COORD_W-1:0]            dx_c, dy_c;
	logic [DIST_W-1:0]             dist_c;
	logic                          better_c;
	logic [IDX_W+MATCH_IDX_W-1:0]  best_idx_ext;

	// status back to the controller
	assign not_full      = (count_q != CNT_W'(MAX_POINTS));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (cmd.load && not_full) begin
			mem_x[count_q[IDX_W-1:0]] <= point_x;
			mem_y[count_q[IDX_W-1:0]] <= point_y;
		end
	end

	// fill count and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.load && not_full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start) begin
				scan_idx_q <= '0;
			end else if (cmd.issue) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
		end
	end

	// query point capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q <= point_x;
			qy_q <= point_y;
		end
	end

	// stage 1: registered store read
	always_ff @(posedge clk) begin
		rd_x_s1 <= mem_x[scan_idx_q];
		rd_y_s1 <= mem_y[scan_idx_q];
		idx_s1  <= scan_idx_q;
	end

	// stage 2: absolute differences and band test
	assign dx_c = (qx_q >= rd_x_s1) ? (qx_q - rd_x_s1) : (rd_x_s1 - qx_q);
	assign dy_c = (qy_q >= rd_y_s1) ? (qy_q - rd_y_s1) : (rd_y_s1 - qy_q);

	always_ff @(posedge clk) begin
		dx_s2  <= dx_c;
		dy_s2  <= dy_c;
		ok_s2  <= (dy_c <= tol_q);
		idx_s2 <= idx_s1;
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		ok_s3  <= ok_s2;
		idx_s3 <= idx_s2;
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// sum and compare with the best so far; strict less keeps the earliest on a tie
	assign dist_c   = DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
	assign better_c = vld_s3 && ok_s3 && (!found_q || (dist_c < best_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (better_c) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better_c) begin
			best_dist_q <= dist_c;
			best_idx_q  <= idx_s3;
		end
	end

	// result register, low index bits only
	assign best_idx_ext = {{MATCH_IDX_W{1'b0}}, best_idx_q};

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			match_found_q <= found_q;
			match_index_q <= found_q ? best_idx_ext[MATCH_IDX_W-1:0] : '0;
		end
	end

	assign match_found = match_found_q;
	assign match_index = match_index_q;

endmodule

### src/snpm_checker.sv
// port-level checks of the matcher, attached to the top level by bind
// depends on snpm_pkg and stereo_nearest_point_matcher_unit_assert.svh
`timescale 1ns / 1ps
`include "stereo_nearest_point_matcher_unit_assert.svh"

module snpm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [snpm_pkg::OP_W-1:0]          opcode,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               match_found,
	input logic [snpm_pkg::MATCH_IDX_W-1:0]   match_index
);
	import snpm_pkg::*;

	// a stalled result holds
	`SNPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(match_found) && $stable(match_index), "stalled result changed")

	// a miss reports index zero
	`SNPM_ASSERT_SAME(a_miss_index, out_valid && !match_found, match_index == '0, "miss with non-zero index")

	// an accepted query occupies the block
	`SNPM_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (opcode == OP_QUERY), in_stall, "input open right after a query")

	// after clear, load or an unused code the input stays open
	`SNPM_ASSERT_NEXT(a_short_op, in_valid && !in_stall && (opcode != OP_QUERY), !in_stall, "input stalled after a short transaction")

endmodule

bind stereo_nearest_point_matcher_unit snpm_checker u_snpm_checker (.*);
